>>> rtl/clk24_pkg.sv
// Shared types, constants and digit helpers for the 24-hour clock block.
// No dependencies; imported by every module of the block.
`default_nettype none

package clk24_pkg;

   typedef enum logic [1:0] {
      MODE_RUN        = 2'd0,
      MODE_ADJ_HOUR   = 2'd1,
      MODE_SET_MINUTE = 2'd2
   } mode_type;

   typedef enum logic {
      REG_TICKS_PER_SECOND = 1'b0,
      REG_TICKS_PER_BLINK  = 1'b1
   } csr_index_type;

   localparam logic [4:0] HOUR_MAX   = 5'd23;
   localparam logic [5:0] MINUTE_MAX = 6'd59;
   localparam logic [5:0] SECOND_MAX = 6'd59;
   localparam logic [4:0] HOUR_RESET = 5'd12;
   localparam logic [7:0] TPS_RESET  = 8'd20;
   localparam logic [7:0] TPB_RESET  = 8'd5;
   localparam logic [7:0] COLON_BIT  = 8'h80;

   // Time and mode after one transaction, handed from core to display
   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      mode_type   mode;
      logic       blink;
   } view_type;

   // Common-cathode pattern, bit 0 = a .. bit 6 = g; blank above 9
   function automatic logic [7:0] seven_seg_of(input logic [3:0] digit);
      logic [7:0] pat;
      case (digit)
         4'd0:    pat = 8'h3F;
         4'd1:    pat = 8'h06;
         4'd2:    pat = 8'h5B;
         4'd3:    pat = 8'h4F;
         4'd4:    pat = 8'h66;
         4'd5:    pat = 8'h6D;
         4'd6:    pat = 8'h7D;
         4'd7:    pat = 8'h07;
         4'd8:    pat = 8'h7F;
         4'd9:    pat = 8'h6F;
         default: pat = 8'h00;
      endcase
      return pat;
   endfunction

   // Tens digit of a value below 64
   function automatic logic [2:0] tens_of(input logic [5:0] value);
      logic [2:0] t;
      if (value >= 6'd60)      t = 3'd6;
      else if (value >= 6'd50) t = 3'd5;
      else if (value >= 6'd40) t = 3'd4;
      else if (value >= 6'd30) t = 3'd3;
      else if (value >= 6'd20) t = 3'd2;
      else if (value >= 6'd10) t = 3'd1;
      else                     t = 3'd0;
      return t;
   endfunction

   function automatic logic [3:0] units_of(input logic [5:0] value);
      logic [2:0] t;
      logic [5:0] ten_mul;
      logic [5:0] rem;
      t       = tens_of(value);
      ten_mul = {t, 3'b000} - {2'b00, t, 1'b0} + {1'b0, t, 2'b00};
      rem     = value - ten_mul;
      return rem[3:0];
   endfunction

endpackage

`default_nettype wire

>>> rtl/clk24_time_core.sv
// Clock state: config registers, button edge detect, set logic, prescalers.
// Depends on clk24_pkg; presents next-state view to the display encoder.
`default_nettype none

module clk24_time_core
   import clk24_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic       tick,
   input  wire logic       mode_button,
   input  wire logic       up_button,
   input  wire logic       down_button,
   input  wire logic       csr_we,
   input  wire logic       csr_addr,
   input  wire logic [7:0] csr_wdata,
   output view_type        view_next
);

   logic [7:0] tps_ff;
   logic [7:0] tpb_ff;
   logic [4:0] hour_ff,  hour_in;
   logic [5:0] minute_ff, minute_in;
   logic [5:0] second_ff, second_in;
   logic [7:0] tick_pre_ff, tick_pre_in;
   logic [7:0] blink_pre_ff, blink_pre_in;
   logic       blink_ff, blink_in;
   mode_type   mode_ff, mode_in;
   logic       mode_last_ff, mode_last_in;
   logic       up_last_ff, up_last_in;
   logic       down_last_ff, down_last_in;

   logic       up_hit;
   logic       down_hit;
   logic [4:0] hour_set;
   logic [5:0] minute_set;
   logic [5:0] second_set;
   logic [7:0] tick_pre_inc;
   logic [7:0] blink_pre_inc;

   assign up_hit        = up_last_ff & ~up_button;
   assign down_hit      = down_last_ff & ~down_button;
   assign tick_pre_inc  = tick_pre_ff + 8'd1;
   assign blink_pre_inc = blink_pre_ff + 8'd1;

   always_comb begin
      mode_in      = mode_ff;
      mode_last_in = mode_button;
      if (mode_last_ff && !mode_button) begin
         unique case (mode_ff)
            MODE_RUN:        mode_in = MODE_ADJ_HOUR;
            MODE_ADJ_HOUR:   mode_in = MODE_SET_MINUTE;
            MODE_SET_MINUTE: mode_in = MODE_RUN;
            default:         mode_in = MODE_RUN;
         endcase
      end
   end

   // Up applied before down within one transaction
   always_comb begin
      up_last_in   = up_last_ff;
      down_last_in = down_last_ff;
      hour_set     = hour_ff;
      minute_set   = minute_ff;
      second_set   = second_ff;
      if (mode_in == MODE_ADJ_HOUR) begin
         up_last_in   = up_button;
         down_last_in = down_button;
         if (up_hit) begin
            hour_set = (hour_set >= HOUR_MAX) ? 5'd0 : hour_set + 5'd1;
         end
         if (down_hit) begin
            hour_set = (hour_set == 5'd0) ? HOUR_MAX : hour_set - 5'd1;
         end
      end else if (mode_in == MODE_SET_MINUTE) begin
         up_last_in   = up_button;
         down_last_in = down_button;
         if (up_hit) begin
            minute_set = (minute_set >= MINUTE_MAX) ? 6'd0 : minute_set + 6'd1;
            second_set = 6'd0;
         end
         if (down_hit) begin
            minute_set = (minute_set == 6'd0) ? MINUTE_MAX : minute_set - 6'd1;
            second_set = 6'd0;
         end
      end
   end

   always_comb begin
      hour_in      = hour_set;
      minute_in    = minute_set;
      second_in    = second_set;
      tick_pre_in  = tick_pre_ff;
      blink_pre_in = blink_pre_ff;
      blink_in     = blink_ff;
      if (tick) begin
         if (tick_pre_inc >= tps_ff) begin
            tick_pre_in = 8'd0;
            if (second_set >= SECOND_MAX) begin
               second_in = 6'd0;
               if (minute_set >= MINUTE_MAX) begin
                  minute_in = 6'd0;
                  hour_in   = (hour_set >= HOUR_MAX) ? 5'd0 : hour_set + 5'd1;
               end else begin
                  minute_in = minute_set + 6'd1;
               end
            end else begin
               second_in = second_set + 6'd1;
            end
         end else begin
            tick_pre_in = tick_pre_inc;
         end
         if (blink_pre_inc >= tpb_ff) begin
            blink_pre_in = 8'd0;
            blink_in     = ~blink_ff;
         end else begin
            blink_pre_in = blink_pre_inc;
         end
      end
   end

   assign view_next = '{hour: hour_in, minute: minute_in, second: second_in,
                        mode: mode_in, blink: blink_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff <= TPS_RESET;
         tpb_ff <= TPB_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            REG_TICKS_PER_SECOND: tps_ff <= csr_wdata;
            REG_TICKS_PER_BLINK:  tpb_ff <= csr_wdata;
            default:              tps_ff <= tps_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hour_ff      <= HOUR_RESET;
         minute_ff    <= 6'd0;
         second_ff    <= 6'd0;
         tick_pre_ff  <= 8'd0;
         blink_pre_ff <= 8'd0;
         blink_ff     <= 1'b0;
         mode_ff      <= MODE_RUN;
         mode_last_ff <= 1'b1;
         up_last_ff   <= 1'b1;
         down_last_ff <= 1'b1;
      end else if (accept) begin
         hour_ff      <= hour_in;
         minute_ff    <= minute_in;
         second_ff    <= second_in;
         tick_pre_ff  <= tick_pre_in;
         blink_pre_ff <= blink_pre_in;
         blink_ff     <= blink_in;
         mode_ff      <= mode_in;
         mode_last_ff <= mode_last_in;
         up_last_ff   <= up_last_in;
         down_last_ff <= down_last_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/clk24_display.sv
// Seven-segment encoder: digit split, blanking of the field being set, colon.
// Depends on clk24_pkg; purely combinational.
`default_nettype none

module clk24_display
   import clk24_pkg::*;
(
   input  wire view_type    view,
   output logic      [7:0] seg_hour_tens,
   output logic      [7:0] seg_hour_units,
   output logic      [7:0] seg_minute_tens,
   output logic      [7:0] seg_minute_units
);

   logic       show_hour;
   logic       show_minute;
   logic [5:0] hour_wide;
   logic [7:0] hour_units_pat;

   assign show_hour   = !(view.mode == MODE_ADJ_HOUR && !view.blink);
   assign show_minute = !(view.mode == MODE_SET_MINUTE && !view.blink);
   assign hour_wide   = {1'b0, view.hour};

   assign hour_units_pat = seven_seg_of(units_of(hour_wide));

   always_comb begin
      seg_hour_tens    = 8'h00;
      seg_hour_units   = 8'h00;
      seg_minute_tens  = 8'h00;
      seg_minute_units = 8'h00;
      if (show_hour) begin
         seg_hour_tens  = seven_seg_of({1'b0, tens_of(hour_wide)});
         seg_hour_units = hour_units_pat;
         if (view.mode == MODE_RUN && view.blink) begin
            seg_hour_units = hour_units_pat | COLON_BIT;
         end
      end
      if (show_minute) begin
         seg_minute_tens  = seven_seg_of({1'b0, tens_of(view.minute)});
         seg_minute_units = seven_seg_of(units_of(view.minute));
      end
   end

endmodule

`default_nettype wire

>>> rtl/settable_24h_clock_with_display_top.sv
// Top level of the settable 24-hour clock: stream ports and result register.
// Depends on clk24_pkg, clk24_time_core and clk24_display.
//
// One sample transaction in, one result transaction out. Each sample is
// applied in order: mode edge, then up/down edges in a set mode,
// then the tick, and the encoded display is captured in the result register
// at the accepting edge and offered from the next cycle on. A new sample is
// taken every cycle while the result register is empty or being drained;
// throughput is then one transaction per cycle. The user must write period
// registers through csr_* only while no sample is in flight; the block has no check for it.
`default_nettype none

module settable_24h_clock_with_display_top
   import clk24_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // tick, mode_button, up_button, down_button, pad
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [55:0] rsp_tdata,   // hour_now[4:0], minute_now[10:5],
                                         // second_now[16:11], mode_now[18:17],
                                         // seg_hour_tens[26:19], seg_hour_units[34:27],
                                         // seg_minute_tens[42:35],
                                         // seg_minute_units[50:43], pad
   input  wire logic        csr_we,
   input  wire logic        csr_addr,
   input  wire logic [7:0]  csr_wdata
);

   logic        accept;
   view_type    view_next;
   logic [7:0]  seg_ht, seg_hu, seg_mt, seg_mu;
   logic        rsp_valid_ff;
   logic [55:0] rsp_data_ff, rsp_data_in;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   clk24_time_core u_core (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .tick        (req_tdata[0]),
      .mode_button (req_tdata[1]),
      .up_button   (req_tdata[2]),
      .down_button (req_tdata[3]),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .view_next   (view_next)
   );

   clk24_display u_display (
      .view             (view_next),
      .seg_hour_tens    (seg_ht),
      .seg_hour_units   (seg_hu),
      .seg_minute_tens  (seg_mt),
      .seg_minute_units (seg_mu)
   );

   assign rsp_data_in = {5'd0, seg_mu, seg_mt, seg_hu, seg_ht, 2'(view_next.mode),
                         view_next.second, view_next.minute, view_next.hour};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire
